>>> src/rrfb_pkg.sv
// Shared types, constants and arithmetic helpers for the rounded rectangle
// fill and blend pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrfb_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 128;
  localparam int CRD_W        = 13;

  localparam int SQ_STEPS  = 25;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int REM_W     = 27;
  localparam int ROOT_W    = 25;
  localparam int RAD_W     = 18;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_BOTTOM = 3'd3,
    REG_RADII  = 3'd4,
    REG_FILL   = 3'd5,
    REG_MODE   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_FULL = 2'd1,
    CLS_ARC  = 2'd2
  } cls_t;

  typedef logic [3:0][7:0] rgba_t;

  typedef struct packed {
    logic [7:0]  left;
    logic [6:0]  top;
    logic [7:0]  right;
    logic [6:0]  bottom;
    logic [31:0] radii;
    rgba_t       fill;
    logic        mode;
  } cfg_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] rad;
    rgba_t      dst;
  } sb_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // One digit-by-digit square root step, two radicand bits in.
  function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] pair);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sq_t              res;
    t     = {cur.rem, pair};
    trial = {1'b0, cur.root, 2'b01};
    if (t >= trial) begin
      res.rem  = REM_W'(t - trial);
      res.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = t[REM_W-1:0];
      res.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // Truncating divide by 255, exact for x up to 65279.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
    return 16'(a) * 16'(b);
  endfunction

endpackage
`default_nettype wire

>>> src/rounded_rect_fill_blend.sv
// Rounded rectangle coverage and blend engine, one pixel per clock when not stalled.
// Depends on rrfb_pkg, rrfb_cover, rrfb_sqrt and rrfb_blend.
`timescale 1ns / 1ps
`default_nettype none
// Shades one pixel per clock: a raster walker feeds pixel coordinates with the
// destination RGBA, and the block returns the blended RGBA and the coverage of
// the configured rounded rectangle. An accepted input passes through 4 geometry
// stages, 13 square root stages (two result bits each, one in the last) and 7
// blend stages, then the output register. Throughput is one item per cycle;
// the whole pipeline advances together and holds only when both the output
// register and the skid entry behind it are full. in_stall is a register, so
// it never depends on out_stall in the same cycle. Write configuration only
// while no item is in flight; the pipeline reads the registers directly. The
// configuration port is always ready, and writes to an index past the register
// list are dropped.
module rounded_rect_fill_blend
  import rrfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [6:0]  in_pixel_y,
  input  wire logic [7:0]  in_dst_red,
  input  wire logic [7:0]  in_dst_green,
  input  wire logic [7:0]  in_dst_blue,
  input  wire logic [7:0]  in_dst_alpha,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [7:0]       out_coverage
);

  cfg_t        cfg_r;

  logic        en;
  logic        cv_valid;
  sb_t         cv_sb;
  logic [16:0] cv_d2;
  logic        sq_valid;
  sb_t         sq_sb;
  logic [ROOT_W-1:0] sq_root;
  logic        bl_valid;
  rgba_t       bl_rgba;
  logic [7:0]  bl_cov;

  logic        out_v_r, skid_v_r;
  rgba_t       out_rgba_r, skid_rgba_r;
  logic [7:0]  out_cov_r, skid_cov_r;
  logic        out_take;

  // Configuration registers; always accept a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{left: 8'd0, top: 7'd0, right: 8'd0, bottom: 7'd0,
                 radii: 32'd0, fill: '0, mode: 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_LEFT:   cfg_r.left   <= cfg_data[7:0];
        REG_TOP:    cfg_r.top    <= cfg_data[6:0];
        REG_RIGHT:  cfg_r.right  <= cfg_data[7:0];
        REG_BOTTOM: cfg_r.bottom <= cfg_data[6:0];
        REG_RADII:  cfg_r.radii  <= cfg_data;
        REG_FILL:   cfg_r.fill   <= cfg_data;
        REG_MODE:   cfg_r.mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the skid entry is occupied.
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  rrfb_cover u_cover (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .i_valid (in_valid),
    .i_x     (in_pixel_x),
    .i_y     (in_pixel_y),
    .i_dst   ({in_dst_alpha, in_dst_blue, in_dst_green, in_dst_red}),
    .o_valid (cv_valid),
    .o_sb    (cv_sb),
    .o_d2    (cv_d2)
  );

  rrfb_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .i_valid (cv_valid),
    .i_sb    (cv_sb),
    .i_d2    (cv_d2),
    .o_valid (sq_valid),
    .o_sb    (sq_sb),
    .o_root  (sq_root)
  );

  rrfb_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg_r),
    .i_valid (sq_valid),
    .i_sb    (sq_sb),
    .i_root  (sq_root),
    .o_valid (bl_valid),
    .o_rgba  (bl_rgba),
    .o_cov   (bl_cov)
  );

  // Output register with one skid entry behind it. A finished item goes to
  // the output when it is free or being taken, else parks in the skid entry.
  assign out_take = out_v_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (bl_valid) begin
      if (!out_v_r || out_take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_rgba_r <= skid_rgba_r;
        out_cov_r  <= skid_cov_r;
      end
    end else if (bl_valid) begin
      if (!out_v_r || out_take) begin
        out_rgba_r <= bl_rgba;
        out_cov_r  <= bl_cov;
      end else begin
        skid_rgba_r <= bl_rgba;
        skid_cov_r  <= bl_cov;
      end
    end
  end

  assign out_valid    = out_v_r;
  assign out_red      = out_rgba_r[0];
  assign out_green    = out_rgba_r[1];
  assign out_blue     = out_rgba_r[2];
  assign out_alpha    = out_rgba_r[3];
  assign out_coverage = out_cov_r;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> !skid_v_r)
    else $error("skid entry did not drain after output was taken");

  a_full_cover_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coverage == 8'd255 && !cfg_r.mode) |->
      (out_red == cfg_r.fill[0] && out_green == cfg_r.fill[1] &&
       out_blue == cfg_r.fill[2] && out_alpha == cfg_r.fill[3]))
    else $error("full coverage in color-set mode must give the fill color");
`endif

endmodule
`default_nettype wire

>>> src/rrfb_cover.sv
// Geometry front end: input register, corner classification, squares and
// squared distance. Depends on rrfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrfb_cover
  import rrfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire cfg_t        cfg,
  input  wire logic        i_valid,
  input  wire logic [7:0]  i_x,
  input  wire logic [6:0]  i_y,
  input  wire rgba_t       i_dst,
  output logic             o_valid,
  output sb_t              o_sb,
  output logic [16:0]      o_d2
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic [7:0]  x1_r;
  logic [6:0]  y1_r;
  rgba_t       dst1_r;
  sb_t         sb2_r, sb3_r, sb4_r, sb2_nxt;
  logic [7:0]  dx2_r, dy2_r, dx_nxt, dy_nxt;
  logic [15:0] sqx3_r, sqy3_r;
  logic [16:0] d24_r;

  logic [9:0] xe, ye, l, t, ri, b, rtl, rbl, rtr, rbr, dxw, dyw;
  logic       in_frame;

  always_comb begin
    xe  = 10'(x1_r);
    ye  = 10'(y1_r);
    l   = 10'(cfg.left);
    t   = 10'(cfg.top);
    ri  = 10'(cfg.right);
    b   = 10'(cfg.bottom);
    rtl = 10'(cfg.radii[7:0]);
    rbl = 10'(cfg.radii[15:8]);
    rtr = 10'(cfg.radii[23:16]);
    rbr = 10'(cfg.radii[31:24]);
    in_frame = (CRD_W'(x1_r) < CRD_W'(FRAME_WIDTH)) && (CRD_W'(y1_r) < CRD_W'(FRAME_HEIGHT));
    dxw = '0;
    dyw = '0;
    sb2_nxt.dst = dst1_r;
    sb2_nxt.rad = '0;
    sb2_nxt.cls = CLS_FULL;
    if (!in_frame || xe < l || xe > ri || ye < t || ye > b) begin
      sb2_nxt.cls = CLS_ZERO;
    end else if (xe < l + rtl && ye < t + rtl) begin
      sb2_nxt.cls = CLS_ARC;
      sb2_nxt.rad = rtl[7:0];
      dxw = l + rtl - xe;
      dyw = t + rtl - ye;
    end else if (xe + rtr > ri && ye < t + rtr) begin
      sb2_nxt.cls = CLS_ARC;
      sb2_nxt.rad = rtr[7:0];
      dxw = xe + rtr - ri;
      dyw = t + rtr - ye;
    end else if (xe < l + rbl && ye + rbl > b) begin
      sb2_nxt.cls = CLS_ARC;
      sb2_nxt.rad = rbl[7:0];
      dxw = l + rbl - xe;
      dyw = ye + rbl - b;
    end else if (xe + rbr > ri && ye + rbr > b) begin
      sb2_nxt.cls = CLS_ARC;
      sb2_nxt.rad = rbr[7:0];
      dxw = xe + rbr - ri;
      dyw = ye + rbr - b;
    end
    dx_nxt = dxw[7:0];
    dy_nxt = dyw[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= i_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= i_x;
      y1_r   <= i_y;
      dst1_r <= i_dst;
      sb2_r  <= sb2_nxt;
      dx2_r  <= dx_nxt;
      dy2_r  <= dy_nxt;
      sb3_r  <= sb2_r;
      sqx3_r <= mul8(dx2_r, dx2_r);
      sqy3_r <= mul8(dy2_r, dy2_r);
      sb4_r  <= sb3_r;
      d24_r  <= 17'(sqx3_r) + 17'(sqy3_r);
    end
  end

  assign o_valid = v4_r;
  assign o_sb    = sb4_r;
  assign o_d2    = d24_r;

endmodule
`default_nettype wire

>>> src/rrfb_sqrt.sv
// Pipelined 9.16 square root of the squared distance, two result bits per
// stage (one in the last), sideband carried alongside. Depends on rrfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrfb_sqrt
  import rrfb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               i_valid,
  input  wire sb_t                i_sb,
  input  wire logic [16:0]        i_d2,
  output logic                    o_valid,
  output sb_t                     o_sb,
  output logic [ROOT_W-1:0]       o_root
);

  logic [SQ_STAGES-1:0]   v_r;
  sq_t                    sq_r  [SQ_STAGES];
  sq_t                    sq_nxt[SQ_STAGES];
  logic [RAD_W-1:0]       rad_r  [SQ_STAGES];
  logic [RAD_W-1:0]       rad_nxt[SQ_STAGES];
  sb_t                    sb_r  [SQ_STAGES];

  // Each stage consumes the next radicand bit pairs; the low 32 bits are zero.
  always_comb begin
    sq_t              cur;
    logic [RAD_W-1:0] rad;
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        cur = '0;
        rad = {1'b0, i_d2};
      end else begin
        cur = sq_r[s-1];
        rad = rad_r[s-1];
      end
      for (int j = 0; j < SQ_PER; j++) begin
        if (s * SQ_PER + j < SQ_STEPS) begin
          cur = sqrt_step(cur, rad[RAD_W-1:RAD_W-2]);
          rad = {rad[RAD_W-3:0], 2'b00};
        end
      end
      sq_nxt[s]  = cur;
      rad_nxt[s] = rad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ_STAGES-2:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        sq_r[s]  <= sq_nxt[s];
        rad_r[s] <= rad_nxt[s];
        sb_r[s]  <= (s == 0) ? i_sb : sb_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign o_valid = v_r[SQ_STAGES-1];
  assign o_sb    = sb_r[SQ_STAGES-1];
  assign o_root  = sq_r[SQ_STAGES-1].root;

endmodule
`default_nettype wire

>>> src/rrfb_blend.sv
// Coverage from distance, then source-over or coverage-weighted blend in
// seven register stages. Depends on rrfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrfb_blend
  import rrfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire cfg_t              cfg,
  input  wire logic              i_valid,
  input  wire sb_t               i_sb,
  input  wire logic [ROOT_W-1:0] i_root,
  output logic                   o_valid,
  output rgba_t                  o_rgba,
  output logic [7:0]             o_cov
);

  logic [6:0]  v_r;
  rgba_t       dst0_r, dst1_r, dst2_r, dst3_r, dst4_r;
  logic [7:0]  cov0_r, cov1_r, cov2_r, cov3_r, cov4_r, cov5_r, cov6_r;
  logic [15:0] psa1_r, pca3_r, pal3_r;
  logic [3:0][15:0] m0s1_r;
  rgba_t       m0o2_r, m0o3_r, m0o4_r, m0o5_r;
  logic [7:0]  sa2_r, sa3_r, ca4_r, al4_r, al5_r;
  logic [2:0][15:0] mx5_r;
  rgba_t       rgba6_r;

  logic [8:0]        rp1;
  logic signed [25:0] q;
  logic [24:0]       qs;
  logic [7:0]        cov_nxt, ca_nxt;
  rgba_t             m0o_nxt, rgba_nxt;
  logic [3:0][15:0]  m0s_nxt;
  logic [2:0][15:0]  mx_nxt;

  always_comb begin
    rp1 = 9'(i_sb.rad) + 9'd1;
    q   = $signed({1'b0, rp1, 16'h0000}) - $signed({1'b0, i_root});
    qs  = (25'(q[16:0]) << 8) - 25'(q[16:0]);
    case (i_sb.cls)
      CLS_ZERO: cov_nxt = 8'd0;
      CLS_FULL: cov_nxt = 8'd255;
      CLS_ARC: begin
        if (q < 0) begin
          cov_nxt = 8'd0;
        end else if (q > 26'sd65536) begin
          cov_nxt = 8'd255;
        end else begin
          cov_nxt = qs[23:16];
        end
      end
      default: cov_nxt = 8'd0;
    endcase

    for (int i = 0; i < 4; i++) begin
      m0s_nxt[i] = mul8(dst0_r[i], 8'd255 - cov0_r) + mul8(cfg.fill[i], cov0_r);
      m0o_nxt[i] = div255(m0s1_r[i]);
    end

    ca_nxt = (sa3_r == 8'd0) ? 8'd0 : sa3_r + div255(pca3_r);

    for (int i = 0; i < 3; i++) begin
      mx_nxt[i] = mul8(dst4_r[i], 8'd255 - ca4_r) + mul8(cfg.fill[i], ca4_r);
    end

    if (cfg.mode) begin
      for (int i = 0; i < 3; i++) begin
        rgba_nxt[i] = div255(mx5_r[i]);
      end
      rgba_nxt[3] = al5_r;
    end else begin
      rgba_nxt = m0o5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], i_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst0_r  <= i_sb.dst;
      cov0_r  <= cov_nxt;

      dst1_r  <= dst0_r;
      cov1_r  <= cov0_r;
      psa1_r  <= mul8(cfg.fill[3], cov0_r);
      m0s1_r  <= m0s_nxt;

      dst2_r  <= dst1_r;
      cov2_r  <= cov1_r;
      sa2_r   <= div255(psa1_r);
      m0o2_r  <= m0o_nxt;

      dst3_r  <= dst2_r;
      cov3_r  <= cov2_r;
      sa3_r   <= sa2_r;
      m0o3_r  <= m0o2_r;
      pca3_r  <= mul8(8'd255 - sa2_r, 8'd255 - dst2_r[3]);
      pal3_r  <= mul8(sa2_r, 8'd255 - dst2_r[3]);

      dst4_r  <= dst3_r;
      cov4_r  <= cov3_r;
      ca4_r   <= ca_nxt;
      al4_r   <= dst3_r[3] + div255(pal3_r);
      m0o4_r  <= m0o3_r;

      cov5_r  <= cov4_r;
      al5_r   <= al4_r;
      m0o5_r  <= m0o4_r;
      mx5_r   <= mx_nxt;

      cov6_r  <= cov5_r;
      rgba6_r <= rgba_nxt;
    end
  end

  assign o_valid = v_r[6];
  assign o_rgba  = rgba6_r;
  assign o_cov   = cov6_r;

endmodule
`default_nettype wire

>>> sim/rounded_rect_fill_blend_tb.sv
// Self-checking testbench for the rounded rectangle coverage and blend engine.
// Depends on rrfb_pkg and the rounded_rect_fill_blend RTL.
`timescale 1ns / 1ps
module rounded_rect_fill_blend_tb;
  import rrfb_pkg::*;

  // Index past the end of the register list; writes to it are dropped.
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct {
    logic [7:0] x;
    logic [6:0] y;
    logic [7:0] dr, dg, db, da;
  } pixel_t;

  typedef struct {
    logic [7:0] r, g, b, a, cov;
  } shade_t;

  logic        clk, rst_n;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic [7:0]  in_pixel_x;
  logic [6:0]  in_pixel_y;
  logic [7:0]  in_dst_red, in_dst_green, in_dst_blue, in_dst_alpha;
  logic        out_valid, out_stall;
  logic [7:0]  out_red, out_green, out_blue, out_alpha, out_coverage;

  rounded_rect_fill_blend u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_dst_red(in_dst_red), .in_dst_green(in_dst_green),
    .in_dst_blue(in_dst_blue), .in_dst_alpha(in_dst_alpha),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha), .out_coverage(out_coverage)
  );

  // Local copy of the configuration registers, updated on each write.
  int unsigned m_left, m_top, m_right, m_bottom, m_radii, m_fill, m_mode;

  pixel_t pixel_q[$];
  shade_t shade_q[$];
  int     errors;
  int     n_accepted;
  bit     quiet;       // no random idling while set
  bit     pix_taken;
  bit     hold_done;
  int     rx_hold;
  pixel_t cur;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

  // Bitwise square root of a 64-bit value, truncated.
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned rem, res, bt;
    rem = v;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic int arc_level(input int x, input int y, input int cx, input int cy,
                                   input int r);
    longint dx, dy, q;
    longint unsigned d2, dlen;
    dx   = x - cx;
    dy   = y - cy;
    d2   = longint'(dx * dx + dy * dy);
    dlen = root64(d2 << 32);
    q    = longint'(r + 1) * 65536 - longint'(dlen);
    if (q < 0) return 0;
    if (q > 65536) return 255;
    return int'((q * 255) >> 16);
  endfunction

  function automatic int shape_cover(input int x, input int y);
    int x0, y0, x1, y1, rtl, rbl, rtr, rbr;
    x0  = m_left;  y0 = m_top;  x1 = m_right;  y1 = m_bottom;
    rtl = m_radii & 8'hFF;
    rbl = (m_radii >> 8) & 8'hFF;
    rtr = (m_radii >> 16) & 8'hFF;
    rbr = (m_radii >> 24) & 8'hFF;
    if (x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return 0;
    if (x < x0 || x > x1 || y < y0 || y > y1) return 0;
    if (x < x0 + rtl && y < y0 + rtl) return arc_level(x, y, x0 + rtl, y0 + rtl, rtl);
    if (x > x1 - rtr && y < y0 + rtr) return arc_level(x, y, x1 - rtr, y0 + rtr, rtr);
    if (x < x0 + rbl && y > y1 - rbl) return arc_level(x, y, x0 + rbl, y1 - rbl, rbl);
    if (x > x1 - rbr && y > y1 - rbr) return arc_level(x, y, x1 - rbr, y1 - rbr, rbr);
    return 255;
  endfunction

  function automatic shade_t shade_pixel(input pixel_t p);
    int unsigned d[4], f[4], o[4];
    int unsigned cov, sa, ca;
    shade_t s;
    d[0] = p.dr; d[1] = p.dg; d[2] = p.db; d[3] = p.da;
    for (int i = 0; i < 4; i++) f[i] = (m_fill >> (8 * i)) & 8'hFF;
    cov = shape_cover(p.x, p.y);
    if (m_mode != 0) begin
      sa = f[3] * cov / 255;
      ca = (sa > 0) ? sa + (255 - sa) * (255 - d[3]) / 255 : 0;
      for (int i = 0; i < 3; i++) o[i] = (d[i] * (255 - ca) + f[i] * ca) / 255;
      o[3] = d[3] + sa * (255 - d[3]) / 255;
    end else begin
      for (int i = 0; i < 4; i++) o[i] = (d[i] * (255 - cov) + f[i] * cov) / 255;
    end
    s.r   = o[0][7:0];
    s.g   = o[1][7:0];
    s.b   = o[2][7:0];
    s.a   = o[3][7:0];
    s.cov = cov[7:0];
    return s;
  endfunction

  // Sample both handshakes at the rising edge; predict on input accept.
  always @(posedge clk) begin
    pix_taken = rst_n && in_valid && !in_stall;
    if (pix_taken) begin
      shade_q.push_back(shade_pixel(cur));
      n_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (shade_q.size() == 0) begin
        $display("%0t: result with nothing expected: rgba %h %h %h %h cov %h", $time,
                 out_red, out_green, out_blue, out_alpha, out_coverage);
        errors++;
      end else begin
        shade_t e;
        e = shade_q.pop_front();
        if (out_red !== e.r)
          begin $display("%0t: red exp %h got %h", $time, e.r, out_red); errors++; end
        if (out_green !== e.g)
          begin $display("%0t: green exp %h got %h", $time, e.g, out_green); errors++; end
        if (out_blue !== e.b)
          begin $display("%0t: blue exp %h got %h", $time, e.b, out_blue); errors++; end
        if (out_alpha !== e.a)
          begin $display("%0t: alpha exp %h got %h", $time, e.a, out_alpha); errors++; end
        if (out_coverage !== e.cov)
          begin $display("%0t: cov exp %h got %h", $time, e.cov, out_coverage); errors++; end
      end
    end
  end

  // Driver: hold a stalled item, advance on accept, idle now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pix_taken) begin
      if (pixel_q.size() != 0 && (quiet || $urandom_range(99) >= 7)) begin
        cur = pixel_q.pop_front();
        in_valid     <= 1'b1;
        in_pixel_x   <= cur.x;
        in_pixel_y   <= cur.y;
        in_dst_red   <= cur.dr;
        in_dst_green <= cur.dg;
        in_dst_blue  <= cur.db;
        in_dst_alpha <= cur.da;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the pipeline.
  always @(negedge clk) begin
    if (!hold_done && n_accepted >= 400) begin
      hold_done = 1'b1;
      rx_hold   = 300;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEFT:   m_left   = 32'(val[7:0]);
      REG_TOP:    m_top    = 32'(val[6:0]);
      REG_RIGHT:  m_right  = 32'(val[7:0]);
      REG_BOTTOM: m_bottom = 32'(val[6:0]);
      REG_RADII:  m_radii  = val;
      REG_FILL:   m_fill   = val;
      REG_MODE:   m_mode   = 32'(val[0]);
      default: ;
    endcase
  endtask

  task automatic set_shape(input int l, input int t, input int r, input int b,
                           input logic [31:0] radii, input logic [31:0] fill,
                           input bit mode);
    reg_write(REG_LEFT, l);
    reg_write(REG_TOP, t);
    reg_write(REG_RIGHT, r);
    reg_write(REG_BOTTOM, b);
    reg_write(REG_RADII, radii);
    reg_write(REG_FILL, fill);
    reg_write(REG_MODE, {31'd0, mode});
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until nothing is queued, offered or outstanding.
  task automatic drain();
    do @(posedge clk); while (pixel_q.size() != 0 || in_valid || shade_q.size() != 0);
  endtask

  task automatic push_pixel(input int x, input int y, input logic [31:0] dst);
    pixel_t p;
    p.x  = x[7:0]; p.y = y[6:0];
    p.dr = dst[7:0]; p.dg = dst[15:8]; p.db = dst[23:16]; p.da = dst[31:24];
    pixel_q.push_back(p);
  endtask

  // Mostly pixels near the shape and its corners, some anywhere in the frame.
  task automatic push_random(input int n);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        x = $urandom_range(255);
        y = $urandom_range(127);
      end else begin
        x = int'(m_left) - 4 + $urandom_range(int'(m_right - m_left) + 8);
        y = int'(m_top) - 4 + $urandom_range(int'(m_bottom - m_top) + 8);
        if (m_left > m_right) x = $urandom_range(255);
        if (m_top > m_bottom) y = $urandom_range(127);
        x = (x < 0) ? 0 : (x > 255 ? 255 : x);
        y = (y < 0) ? 0 : (y > 127 ? 127 : y);
      end
      push_pixel(x, y, $urandom);
    end
  endtask

  initial begin
    int l, t, r, b;
    errors     = 0;
    n_accepted = 0;
    quiet      = 1'b0;
    hold_done  = 1'b0;
    rx_hold    = 0;
    pix_taken  = 1'b0;
    m_left = 0; m_top = 0; m_right = 0; m_bottom = 0;
    m_radii = 0; m_fill = 0; m_mode = 1;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_LEFT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_pixel_x   = '0;
    in_pixel_y   = '0;
    in_dst_red   = '0;
    in_dst_green = '0;
    in_dst_blue  = '0;
    in_dst_alpha = '0;
    out_stall    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: a single-pixel shape at the origin.
    push_pixel(0, 0, 32'h80402010);
    push_pixel(1, 0, 32'hFFFFFFFF);
    drain();

    // Directed: full-frame shape, radius 10 corners, blend mode.
    set_shape(0, 0, 255, 127, 32'h0A0A0A0A, 32'hC0FF8000, 1'b1);
    push_pixel(0, 0, 32'h00000000);
    push_pixel(255, 0, 32'hFFFFFFFF);
    push_pixel(0, 127, 32'h00FF00FF);
    push_pixel(255, 127, 32'hFF00FF00);
    push_pixel(128, 64, 32'h12345678);
    push_pixel(3, 3, 32'h00000000);
    push_pixel(10, 10, 32'h7F7F7F7F);
    push_pixel(2, 8, 32'hFF000000);
    push_pixel(252, 4, 32'h000000FF);
    push_pixel(4, 123, 32'hA5A5A5A5);
    push_pixel(250, 122, 32'h5A5A5A5A);
    drain();
    // Zero coverage passes the destination through; empty rectangle.
    set_shape(200, 100, 10, 5, 32'h01020304, 32'hFFFFFFFF, 1'b1);
    push_pixel(50, 50, 32'hDEADBEEF);
    push_pixel(200, 100, 32'h01234567);
    drain();
    // Oversized radii in color-set mode with opaque fill, then blend mode with clear fill.
    set_shape(20, 10, 40, 30, 32'hFFFFFFFF, 32'hFF112233, 1'b0);
    push_pixel(20, 10, 32'h00000000);
    push_pixel(30, 20, 32'hFFFFFFFF);
    push_pixel(40, 30, 32'h80808080);
    push_pixel(19, 10, 32'h11111111);
    drain();
    set_shape(0, 0, 255, 127, 32'h00000000, 32'h00FFFFFF, 1'b1);
    push_pixel(5, 5, 32'h40302010);
    push_pixel(255, 127, 32'h00000000);
    drain();
    reg_write(REG_NONE, 32'hFFFFFFFF);
    @(negedge clk);
    cfg_valid = 1'b0;
    push_pixel(9, 9, 32'hFFFFFFFF);
    drain();

    // Random phases over several shapes, the extremes among them.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_shape(0, 0, 255, 127, 32'h7F7F7F7F, 32'hFFFFFFFF, 1'b1);
        1: set_shape(0, 0, 255, 127, 32'hFFFFFFFF, 32'h00000000, 1'b0);
        2: set_shape(100, 50, 100, 50, 32'h00000001, 32'h80808080, 1'b1);
        3: set_shape(255, 127, 0, 0, $urandom, $urandom, 1'b0);
        default: begin
          l = $urandom_range(200); r = l + $urandom_range(255 - l);
          t = $urandom_range(100); b = t + $urandom_range(127 - t);
          set_shape(l, t, r, b,
                    {4{8'($urandom_range(($urandom_range(3) == 0) ? 255 : 30))}} ^
                      ($urandom_range(1) ? 32'h0 : 32'h03050709),
                    $urandom, $urandom_range(1));
        end
      endcase
      quiet = (ph == 6);
      if (ph == 4) begin
        // Let the sender run dry until every result is back, then resume.
        push_random(90);
        drain();
        push_random(90);
      end else begin
        push_random(180);
      end
      drain();
    end
    quiet = 1'b0;

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> rounded_rect_fill_blend.f
src/rrfb_pkg.sv
src/rrfb_cover.sv
src/rrfb_sqrt.sv
src/rrfb_blend.sv
src/rounded_rect_fill_blend.sv
sim/rounded_rect_fill_blend_tb.sv
